// File: rtl/nsrl_pkg.sv
// Shared types and constants for the nearest-seed region labeler.
package nsrl_pkg;

  localparam int unsigned MAX_SEEDS_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned COORD_PORT_W   = 16;
  localparam int unsigned LABEL_W        = 8;

  // Squared distances at or above the limit never match, so a best
  // distance always fits in 27 bits.
  localparam int unsigned BEST_W = 27;
  localparam logic [BEST_W-1:0] DIST_LIMIT = 27'd100000000;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_CLASSIFY = 2'd2
  } nsrl_op_e;

  // Control part of a pixel token moving down the cell chain.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [LABEL_W-1:0] idx;
  } nsrl_ctl_t;

endpackage

// File: rtl/nearest_seed_region_labeler.sv
// Top level of the nearest-seed region labeler: seed table as a cell chain.
//
//   channel | direction | fields                          | handshake
//   --------+-----------+---------------------------------+------------------------
//   in      | input     | opcode_i, coord_x_i, coord_y_i  | in_valid_i / in_ready_o
//   out     | output    | region_label_o, matched_o       | out_valid_o / out_ready_i
//
// A classify word passes through the chain (two register stages per seed cell) and then
// the output register; one pixel may enter every cycle while the output is not stalled.
// Add and clear words are taken only once no pixel is left in the chain, so a stream of
// pixels runs at one per cycle unless the output stalls; a seed change waits for a drain.
// Reset empties the seed table and the chain. A stalled output freezes the whole chain.
module nearest_seed_region_labeler
  import nsrl_pkg::*;
#(
  parameter int unsigned MAX_SEEDS  = MAX_SEEDS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              opcode_i,
  input  logic [COORD_PORT_W-1:0] coord_x_i,
  input  logic [COORD_PORT_W-1:0] coord_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [LABEL_W-1:0]      region_label_o,
  output logic                    matched_o
);

  localparam int unsigned CNT_W    = $clog2(MAX_SEEDS + 1);
  localparam int unsigned DEPTH    = 2 * MAX_SEEDS;
  localparam int unsigned FLIGHT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0]    seed_cnt_q, seed_cnt_d;
  logic [FLIGHT_W-1:0] flight_q, flight_d;
  logic                out_valid_q;
  logic [LABEL_W-1:0]  label_q;
  logic                matched_q;

  logic en, drained, fire, do_clear, do_add, do_class, leave;
  logic [COORD_BITS-1:0] px_in, py_in;

  nsrl_ctl_t             ctl  [MAX_SEEDS+1];
  logic [COORD_BITS-1:0] px   [MAX_SEEDS+1];
  logic [COORD_BITS-1:0] py   [MAX_SEEDS+1];
  logic [BEST_W-1:0]     best [MAX_SEEDS+1];

  assign en      = !out_valid_q || out_ready_i;
  assign drained = (flight_q == '0);

  always_comb begin
    unique case (opcode_i) inside
      OP_CLASSIFY:      in_ready_o = en;
      OP_CLEAR, OP_ADD: in_ready_o = drained;
      default:          in_ready_o = 1'b1;
    endcase
  end

  assign fire     = in_valid_i && in_ready_o;
  assign do_clear = fire && (opcode_i == OP_CLEAR);
  assign do_add   = fire && (opcode_i == OP_ADD) && (seed_cnt_q < CNT_W'(MAX_SEEDS));
  assign do_class = fire && (opcode_i == OP_CLASSIFY);
  assign leave    = en && ctl[MAX_SEEDS].valid;

  assign px_in = coord_x_i[COORD_BITS-1:0];
  assign py_in = coord_y_i[COORD_BITS-1:0];

  always_comb begin
    seed_cnt_d = seed_cnt_q;
    if (do_clear) begin
      seed_cnt_d = '0;
    end else if (do_add) begin
      seed_cnt_d = seed_cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    flight_d = flight_q;
    if (do_class && !leave) begin
      flight_d = flight_q + FLIGHT_W'(1);
    end else if (!do_class && leave) begin
      flight_d = flight_q - FLIGHT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_cnt_q  <= '0;
      flight_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seed_cnt_q <= seed_cnt_d;
      flight_q   <= flight_d;
      if (en) begin
        out_valid_q <= ctl[MAX_SEEDS].valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      label_q   <= ctl[MAX_SEEDS].found ? ctl[MAX_SEEDS].idx : '0;
      matched_q <= ctl[MAX_SEEDS].found;
    end
  end

  // Token entering the chain; a bubble when no pixel is taken.
  assign ctl[0]  = '{valid: do_class, found: 1'b0, idx: '0};
  assign px[0]   = px_in;
  assign py[0]   = py_in;
  assign best[0] = DIST_LIMIT;

  for (genvar i = 0; i < MAX_SEEDS; i++) begin : g_cell
    nsrl_cell #(
      .COORD_BITS(COORD_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .clr_i  (do_clear),
      .wr_en_i(do_add && (seed_cnt_q == CNT_W'(i))),
      .wr_x_i (px_in),
      .wr_y_i (py_in),
      .ctl_i  (ctl[i]),
      .px_i   (px[i]),
      .py_i   (py[i]),
      .best_i (best[i]),
      .ctl_o  (ctl[i+1]),
      .px_o   (px[i+1]),
      .py_o   (py[i+1]),
      .best_o (best[i+1])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign region_label_o = label_q;
  assign matched_o      = matched_q;

  a_add_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (opcode_i == OP_ADD || opcode_i == OP_CLEAR)) |-> (flight_q == '0))
    else $error("seed table changed with pixels in the chain");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_cnt_q <= CNT_W'(MAX_SEEDS))
    else $error("seed count above table size");

  a_empty_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flight_q == '0) |-> !ctl[MAX_SEEDS].valid)
    else $error("pixel leaving an empty chain");

  a_unmatched_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> (region_label_o == '0))
    else $error("unmatched pixel with nonzero label");

  a_flight_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q <= FLIGHT_W'(DEPTH))
    else $error("more pixels in flight than chain stages");

endmodule

// File: rtl/nsrl_cell.sv
// One seed cell: holds a seed and updates the passing pixel's best match.
module nsrl_cell
  import nsrl_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  clr_i,
  input  logic                  wr_en_i,
  input  logic [COORD_BITS-1:0] wr_x_i,
  input  logic [COORD_BITS-1:0] wr_y_i,
  input  nsrl_ctl_t             ctl_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic [BEST_W-1:0]     best_i,
  output nsrl_ctl_t             ctl_o,
  output logic [COORD_BITS-1:0] px_o,
  output logic [COORD_BITS-1:0] py_o,
  output logic [BEST_W-1:0]     best_o
);

  localparam int unsigned SQ_W = 2 * COORD_BITS;
  localparam int unsigned DW   = SQ_W + 1;
  localparam int unsigned CW   = (DW > BEST_W) ? DW : BEST_W;
  localparam logic [LABEL_W-1:0] IdxLabel = LABEL_W'(IDX);

  logic                  seed_vld_q;
  logic [COORD_BITS-1:0] seed_x_q, seed_y_q;

  nsrl_ctl_t             ctl_a_q, ctl_b_q, ctl_b_d;
  logic [COORD_BITS-1:0] px_a_q, py_a_q, px_b_q, py_b_q;
  logic [BEST_W-1:0]     best_a_q, best_b_q, best_b_d;
  logic [SQ_W-1:0]       sqx_a_q, sqy_a_q;
  logic [COORD_BITS-1:0] dx, dy;
  logic [DW-1:0]         dist_sq;
  logic                  take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_vld_q <= 1'b0;
    end else if (clr_i) begin
      seed_vld_q <= 1'b0;
    end else if (wr_en_i) begin
      seed_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      seed_x_q <= wr_x_i;
      seed_y_q <= wr_y_i;
    end
  end

  assign dx = (px_i > seed_x_q) ? px_i - seed_x_q : seed_x_q - px_i;
  assign dy = (py_i > seed_y_q) ? py_i - seed_y_q : seed_y_q - py_i;

  // First stage: the two squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_a_q   <= px_i;
      py_a_q   <= py_i;
      best_a_q <= best_i;
      sqx_a_q  <= SQ_W'(dx) * SQ_W'(dx);
      sqy_a_q  <= SQ_W'(dy) * SQ_W'(dy);
    end
  end

  // Second stage: sum and strict compare, so the earlier seed keeps a tie.
  assign dist_sq = DW'(sqx_a_q) + DW'(sqy_a_q);
  assign take    = ctl_a_q.valid && seed_vld_q && (CW'(dist_sq) < CW'(best_a_q));

  always_comb begin
    ctl_b_d  = ctl_a_q;
    best_b_d = best_a_q;
    if (take) begin
      ctl_b_d.found = 1'b1;
      ctl_b_d.idx   = IdxLabel;
      best_b_d      = BEST_W'(dist_sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_b_q <= ctl_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_b_q   <= px_a_q;
      py_b_q   <= py_a_q;
      best_b_q <= best_b_d;
    end
  end

  assign ctl_o  = ctl_b_q;
  assign px_o   = px_b_q;
  assign py_o   = py_b_q;
  assign best_o = best_b_q;

endmodule
